@@ src/tsde_pkg.sv @@
package tsde_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int SUM_W       = 48;
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int MIN_SAMPLES = 6;
  localparam int DROP_W      = SAMPLE_W + 2;
  localparam int N_EXT       = 3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is_last;
  } tsde_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] trimmed_sum;
    logic             too_few;
    logic             too_many;
  } tsde_out_t;

  typedef struct packed {
    logic                take;
    logic [SAMPLE_W-1:0] val;
  } tsde_link_t;

  typedef struct packed {
    logic [SUM_W-1:0]                 sum;
    logic [N_EXT-1:0][SAMPLE_W-1:0]   mins;
    logic [N_EXT-1:0][SAMPLE_W-1:0]   maxs;
    logic                             too_few;
    logic                             too_many;
  } tsde_cap_t;

endpackage

@@ src/trimmed_sum_drop_three_extremes_unit.sv @@
// Trimmed sum over a set of unsigned 32-bit samples: one sample beat per cycle, the set
// closed by a beat with is_last high, which belongs to the set. The block keeps a 48-bit
// running sum and two chains of three cells that hold the three smallest and three largest
// samples; each cycle a sample ripples into both chains and the sum. On the last beat the
// totals are captured and the state clears, so the next set may start in the very next
// cycle. The result passes through a capture register, an add stage for the extremes and
// the output register that takes the difference, and equals the sum minus the six
// extremes, duplicates counted separately. A set of fewer than six samples gives zero
// with too_few; samples past 65536 are ignored and the result is zero with too_many.
// Throughput is one sample per cycle; a stalled output holds only once the three result
// stages are full.
module trimmed_sum_drop_three_extremes_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsde_pkg::tsde_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tsde_pkg::tsde_out_t out_data
);

  logic [tsde_pkg::SUM_W-1:0]  sum_r;
  logic [tsde_pkg::SUM_W-1:0]  sum_nxt;
  logic [tsde_pkg::CNT_W-1:0]  cnt_r;
  logic [tsde_pkg::CNT_W-1:0]  cnt_nxt;
  logic                        ovf_r;
  logic                        ovf_nxt;
  logic                        take;
  logic                        full;
  logic                        en;
  logic                        last;
  logic                        cap_ready;
  tsde_pkg::tsde_cap_t         cap;
  tsde_pkg::tsde_link_t        min_link [tsde_pkg::N_EXT+1];
  tsde_pkg::tsde_link_t        max_link [tsde_pkg::N_EXT+1];
  logic [tsde_pkg::N_EXT-1:0][tsde_pkg::SAMPLE_W-1:0] min_nxt;
  logic [tsde_pkg::N_EXT-1:0][tsde_pkg::SAMPLE_W-1:0] max_nxt;

  assign in_ready = cap_ready;
  assign take     = in_valid && in_ready;
  assign full     = cnt_r == tsde_pkg::CNT_W'(tsde_pkg::MAX_SAMPLES);
  assign en       = take && !full;
  assign last     = take && in_data.is_last;

  assign sum_nxt = en ? sum_r + tsde_pkg::SUM_W'(in_data.sample) : sum_r;
  assign cnt_nxt = en ? cnt_r + tsde_pkg::CNT_W'(1) : cnt_r;
  assign ovf_nxt = ovf_r || (take && full);

  always_ff @(posedge clk) begin
    if (!rst_n || last) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign min_link[0] = '{take: 1'b1, val: in_data.sample};
  assign max_link[0] = '{take: 1'b1, val: in_data.sample};

  for (genvar g = 0; g < tsde_pkg::N_EXT; g++) begin : g_cells
    tsde_cell u_min (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .clr     (last),
      .is_max  (1'b0),
      .sample  (in_data.sample),
      .up      (min_link[g]),
      .dn      (min_link[g+1]),
      .val_nxt (min_nxt[g])
    );
    tsde_cell u_max (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .clr     (last),
      .is_max  (1'b1),
      .sample  (in_data.sample),
      .up      (max_link[g]),
      .dn      (max_link[g+1]),
      .val_nxt (max_nxt[g])
    );
  end

  assign cap.sum      = sum_nxt;
  assign cap.mins     = min_nxt;
  assign cap.maxs     = max_nxt;
  assign cap.too_many = ovf_nxt;
  assign cap.too_few  = !ovf_nxt && (cnt_nxt < tsde_pkg::CNT_W'(tsde_pkg::MIN_SAMPLES));

  tsde_trim u_trim (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_valid (last),
    .cap_ready (cap_ready),
    .cap       (cap),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.too_few && out_data.too_many))
    else $error("too_few and too_many both set");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.too_few || out_data.too_many) |-> out_data.trimmed_sum == '0)
    else $error("flagged result carries a nonzero sum");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= tsde_pkg::CNT_W'(tsde_pkg::MAX_SAMPLES))
    else $error("sample count past maximum");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data.is_last |=> cnt_r == '0 && sum_r == '0 && !ovf_r)
    else $error("set state not cleared after last beat");

  a_min_order: assert property (@(posedge clk) disable iff (!rst_n)
    min_link[1].val <= min_link[2].val && min_link[2].val <= min_link[3].val)
    else $error("smallest-value chain out of order");

endmodule

@@ src/tsde_cell.sv @@
module tsde_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          clr,
  input  logic                          is_max,
  input  logic [tsde_pkg::SAMPLE_W-1:0] sample,
  input  tsde_pkg::tsde_link_t          up,
  output tsde_pkg::tsde_link_t          dn,
  output logic [tsde_pkg::SAMPLE_W-1:0] val_nxt
);

  logic [tsde_pkg::SAMPLE_W-1:0] val_r;
  logic                          better;

  assign better = is_max ? (sample > val_r) : (sample < val_r);

  always_comb begin
    val_nxt = val_r;
    if (en && better) begin
      val_nxt = up.take ? up.val : sample;
    end
  end

  assign dn.take = better;
  assign dn.val  = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      val_r <= {tsde_pkg::SAMPLE_W{~is_max}};
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule

@@ src/tsde_trim.sv @@
module tsde_trim (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cap_valid,
  output logic                 cap_ready,
  input  tsde_pkg::tsde_cap_t  cap,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tsde_pkg::tsde_out_t  out_data
);

  tsde_pkg::tsde_cap_t            s1_r;
  logic                           s1_v_r;
  logic [tsde_pkg::SUM_W-1:0]     s2_sum_r;
  logic [tsde_pkg::DROP_W-1:0]    s2_lo_r;
  logic [tsde_pkg::DROP_W-1:0]    s2_hi_r;
  logic                           s2_few_r;
  logic                           s2_many_r;
  logic                           s2_v_r;
  tsde_pkg::tsde_out_t            out_r;
  logic                           out_v_r;
  logic                           out_rdy;
  logic                           s2_rdy;
  logic                           s1_rdy;
  logic [tsde_pkg::DROP_W-1:0]    lo_nxt;
  logic [tsde_pkg::DROP_W-1:0]    hi_nxt;
  logic [tsde_pkg::SUM_W-1:0]     res_nxt;

  assign out_rdy   = !out_v_r || out_ready;
  assign s2_rdy    = !s2_v_r || out_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign cap_ready = s1_rdy;

  assign lo_nxt = tsde_pkg::DROP_W'(s1_r.mins[0]) + tsde_pkg::DROP_W'(s1_r.mins[1])
                + tsde_pkg::DROP_W'(s1_r.mins[2]);
  assign hi_nxt = tsde_pkg::DROP_W'(s1_r.maxs[0]) + tsde_pkg::DROP_W'(s1_r.maxs[1])
                + tsde_pkg::DROP_W'(s1_r.maxs[2]);

  always_comb begin
    res_nxt = s2_sum_r - tsde_pkg::SUM_W'(s2_lo_r) - tsde_pkg::SUM_W'(s2_hi_r);
    if (s2_few_r || s2_many_r) begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= cap_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_valid && s1_rdy) begin
      s1_r <= cap;
    end
    if (s1_v_r && s2_rdy) begin
      s2_sum_r  <= s1_r.sum;
      s2_lo_r   <= lo_nxt;
      s2_hi_r   <= hi_nxt;
      s2_few_r  <= s1_r.too_few;
      s2_many_r <= s1_r.too_many;
    end
    if (s2_v_r && out_rdy) begin
      out_r.trimmed_sum <= res_nxt;
      out_r.too_few     <= s2_few_r;
      out_r.too_many    <= s2_many_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
